### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file of the triangulator
// no dependencies; simulation builds get the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ECT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ECT_ASSERT_NEVER(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define ECT_ASSERT(lbl, clk, rst, prop, msg)
`define ECT_ASSERT_NEVER(lbl, clk, rst, prop, msg)
`endif
`endif

### rtl/ect_pkg.sv
// shared types and constants of the ear clipping triangulator
// no dependencies; used by ect_xunit and ear_clipping_triangulator
package ect_pkg;

   localparam int EctMaxVerts = 64;
   localparam int CoordW      = 32;
   localparam int DiffW       = CoordW + 1;
   localparam int ProdW       = 2 * DiffW;

   // which cross product the shared unit is asked for
   typedef enum logic [1:0] {
      XS_CONVEX = 2'd0,
      XS_S1     = 2'd1,
      XS_S2     = 2'd2,
      XS_S3     = 2'd3
   } xs_type;

   typedef struct packed {
      logic signed [DiffW-1:0] ux;
      logic signed [DiffW-1:0] uy;
      logic signed [DiffW-1:0] vx;
      logic signed [DiffW-1:0] vy;
   } xop_type;

   typedef struct packed {
      logic done;
      logic neg;
      logic zero;
   } xres_type;

endpackage

### rtl/ect_xunit.sv
// shared exact cross product sign unit: sign of ux*vy - uy*vx
// depends on ect_pkg; one 33x33 multiplier used twice, then a compare
module ect_xunit
   import ect_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  xop_type  op,
   output xres_type res
);

   typedef enum logic [3:0] {
      XU_IDLE = 4'b0001,
      XU_M1   = 4'b0010,
      XU_M2   = 4'b0100,
      XU_CMP  = 4'b1000
   } xu_state_type;

   xu_state_type state_ff, state_in;
   xop_type op_ff;
   logic signed [ProdW-1:0] p_ff, q_ff, prod;
   logic signed [DiffW-1:0] mul_a, mul_b;
   logic done_ff, neg_ff, zero_ff;

   // first pass ux*vy, second pass uy*vx
   always_comb begin
      if (state_ff == XU_M1) begin
         mul_a = op_ff.ux;
         mul_b = op_ff.vy;
      end else begin
         mul_a = op_ff.uy;
         mul_b = op_ff.vx;
      end
      prod = mul_a * mul_b;
   end

   always_comb begin
      case (state_ff)
         XU_IDLE: state_in = start ? XU_M1 : XU_IDLE;
         XU_M1:   state_in = XU_M2;
         XU_M2:   state_in = XU_CMP;
         XU_CMP:  state_in = XU_IDLE;
         default: state_in = XU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= XU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == XU_CMP);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == XU_IDLE && start) op_ff <= op;
      if (state_ff == XU_M1) p_ff <= prod;
      if (state_ff == XU_M2) q_ff <= prod;
      if (state_ff == XU_CMP) begin
         neg_ff  <= (p_ff < q_ff);
         zero_ff <= (p_ff == q_ff);
      end
   end

   assign res = '{done: done_ff, neg: neg_ff, zero: zero_ff};

endmodule

### rtl/ear_clipping_triangulator.sv
// top level of the ear clipping polygon triangulator: vertex store, sequencer, output register
// depends on ect_pkg, ect_xunit and assert_macros.svh
//
//  channel | dir | handshake             | payload
//  req_    | in  | req_tvalid/req_tready | tdata {vertex_y, vertex_x}, tlast last_vertex
//  rsp_    | out | rsp_tvalid/rsp_tready | tdata 6 coords, tlast last_triangle, tuser flags
//
// a vertex transaction without tlast leaves the block ready for the next vertex; the one with tlast
// starts clipping when at least 3 vertices are held; one inside probe runs three cross products in turn
// on the shared multiplier
// req_tready is low from the start of clipping until the last triangle is queued and, unless the
// ear was the last stored vertex, the store is compacted behind it
// a stalled rsp_ side holds the sequencer at the next triangle only
// reset is synchronous; the vertex store needs no clearing since it is written before read
`include "assert_macros.svh"
module ear_clipping_triangulator
   import ect_pkg::*;
#(
   parameter int MAX_VERTS = EctMaxVerts
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // vertex_x [31:0], vertex_y [63:32]
   input  logic         req_tlast,   // last_vertex
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // prev_x, prev_y, ear_x, ear_y, next_x, next_y
   output logic         rsp_tlast,   // last_triangle
   output logic [1:0]   rsp_tuser    // fallback_used [0], vertices_dropped [1]
);

   localparam int IW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam int MW = 2 * CoordW + 1;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_FA   = 12'b000000000010,  // address prev vertex
      ST_FB   = 12'b000000000100,  // capture prev, address center
      ST_FC   = 12'b000000001000,  // capture center, address next
      ST_FD   = 12'b000000010000,  // capture next, dispatch
      ST_FP   = 12'b000000100000,  // address probe vertex
      ST_FQ   = 12'b000001000000,  // capture probe
      ST_XGO  = 12'b000010000000,  // start cross product
      ST_XWT  = 12'b000100000000,  // wait on cross product
      ST_EMIT = 12'b001000000000,  // queue triangle
      ST_SHR  = 12'b010000000000,  // compaction read
      ST_SHW  = 12'b100000000000   // compaction write
   } state_type;

   // what the fetched vertex triple is for
   typedef enum logic [4:0] {
      MD_INIT   = 5'b00001,
      MD_FIX1   = 5'b00010,
      MD_FIX2   = 5'b00100,
      MD_SEARCH = 5'b01000,
      MD_EMIT   = 5'b10000
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   xs_type    xs_ff, xs_in;
   logic [CW-1:0] n_ff, n_in, k_ff, k_in;
   logic [IW-1:0] ci_ff, ci_in, pi_ff, pi_in, si_ff, si_in, ear_ff, ear_in;
   logic ovf_ff, ovf_in, fb_ff, fb_in, apos_ff, apos_in, aneg_ff, aneg_in;

   logic signed [CoordW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff, px_ff, py_ff;
   logic bmark_ff;

   // vertex store: {convex mark, y, x}
   logic [MW-1:0] mem [MAX_VERTS];
   logic [MW-1:0] rd_data_ff, wr_data;
   logic [IW-1:0] rd_addr, wr_addr;
   logic          wr_en;

   logic          rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [191:0]  rsp_data_ff;
   logic          rsp_last_ff;
   logic [1:0]    rsp_user_ff;

   xop_type  xop;
   xres_type xres;
   logic     xstart;

   logic [IW-1:0] prev_ci, next_ci, next_nc, next_pi, nm1;
   logic          req_acc, full, pos3, neg3;
   logic [CW-1:0] n_new, n_dec;
   logic signed [DiffW-1:0] u1x, u1y, u2x, u2y, v1x, v1y, v2x, v2y;

   ect_xunit u_xunit (
      .clock (clock),
      .reset (reset),
      .start (xstart),
      .op    (xop),
      .res   (xres)
   );

   // ring neighbors under the current live count
   assign nm1     = IW'(n_ff - CW'(1));
   assign prev_ci = (ci_ff == '0) ? nm1 : ci_ff - IW'(1);
   assign next_ci = (CW'(ci_ff) + CW'(1) == n_ff) ? '0 : ci_ff + IW'(1);
   assign next_nc = (CW'(next_ci) + CW'(1) == n_ff) ? '0 : next_ci + IW'(1);
   assign next_pi = (CW'(pi_ff) + CW'(1) == n_ff) ? '0 : pi_ff + IW'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign full       = (n_ff == CW'(MAX_VERTS));
   assign n_new      = full ? n_ff : n_ff + CW'(1);
   assign n_dec      = n_ff - CW'(1);
   assign pos3       = !xres.neg && !xres.zero;
   assign neg3       = xres.neg;

   // operand selection for the shared unit: u = u1 - u2, v = v1 - v2
   always_comb begin
      case (xs_ff)
         XS_CONVEX: begin
            u1x = DiffW'(ax_ff); u1y = DiffW'(ay_ff); u2x = DiffW'(bx_ff); u2y = DiffW'(by_ff);
            v1x = DiffW'(cx_ff); v1y = DiffW'(cy_ff); v2x = DiffW'(bx_ff); v2y = DiffW'(by_ff);
         end
         XS_S1: begin
            u1x = DiffW'(bx_ff); u1y = DiffW'(by_ff); u2x = DiffW'(ax_ff); u2y = DiffW'(ay_ff);
            v1x = DiffW'(px_ff); v1y = DiffW'(py_ff); v2x = DiffW'(bx_ff); v2y = DiffW'(by_ff);
         end
         XS_S2: begin
            u1x = DiffW'(cx_ff); u1y = DiffW'(cy_ff); u2x = DiffW'(bx_ff); u2y = DiffW'(by_ff);
            v1x = DiffW'(px_ff); v1y = DiffW'(py_ff); v2x = DiffW'(cx_ff); v2y = DiffW'(cy_ff);
         end
         XS_S3: begin
            u1x = DiffW'(ax_ff); u1y = DiffW'(ay_ff); u2x = DiffW'(cx_ff); u2y = DiffW'(cy_ff);
            v1x = DiffW'(px_ff); v1y = DiffW'(py_ff); v2x = DiffW'(ax_ff); v2y = DiffW'(ay_ff);
         end
         default: begin
            u1x = '0; u1y = '0; u2x = '0; u2y = '0;
            v1x = '0; v1y = '0; v2x = '0; v2y = '0;
         end
      endcase
      xop.ux = u1x - u2x;
      xop.uy = u1y - u2y;
      xop.vx = v1x - v2x;
      xop.vy = v1y - v2y;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      xs_in    = xs_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      ci_in    = ci_ff;
      pi_in    = pi_ff;
      si_in    = si_ff;
      ear_in   = ear_ff;
      ovf_in   = ovf_ff;
      fb_in    = fb_ff;
      apos_in  = apos_ff;
      aneg_in  = aneg_ff;
      rd_addr  = ci_ff;
      wr_en    = 1'b0;
      wr_addr  = ci_ff;
      wr_data  = {1'b0, by_ff, bx_ff};
      xstart   = 1'b0;
      rsp_load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!full) begin
                  wr_en   = 1'b1;
                  wr_addr = n_ff[IW-1:0];
                  wr_data = {1'b0, req_tdata[63:32], req_tdata[31:0]};
               end else begin
                  ovf_in = 1'b1;
               end
               n_in = n_new;
               if (req_tlast) begin
                  if (n_new >= CW'(3)) begin
                     mode_in  = MD_INIT;
                     ci_in    = '0;
                     state_in = ST_FA;
                  end else begin
                     // too short to clip: start over
                     n_in   = '0;
                     ovf_in = 1'b0;
                  end
               end
            end
         end
         ST_FA: begin
            rd_addr  = prev_ci;
            state_in = ST_FB;
         end
         ST_FB: begin
            rd_addr  = ci_ff;
            state_in = ST_FC;
         end
         ST_FC: begin
            rd_addr  = next_ci;
            state_in = ST_FD;
         end
         ST_FD: begin
            case (mode_ff)
               MD_SEARCH: begin
                  if (!bmark_ff) begin
                     // reflex: next candidate, or fall back to vertex 0
                     if (CW'(ci_ff) + CW'(1) == n_ff) begin
                        ci_in = '0; fb_in = 1'b1; mode_in = MD_EMIT;
                     end else begin
                        ci_in = ci_ff + IW'(1);
                     end
                     state_in = ST_FA;
                  end else if (n_ff == CW'(3)) begin
                     fb_in = 1'b0; mode_in = MD_EMIT; state_in = ST_FA;
                  end else begin
                     pi_in    = next_nc;
                     k_in     = n_ff - CW'(3);
                     state_in = ST_FP;
                  end
               end
               MD_EMIT: state_in = ST_EMIT;
               default: begin
                  xs_in    = XS_CONVEX;
                  state_in = ST_XGO;
               end
            endcase
         end
         ST_FP: begin
            rd_addr  = pi_ff;
            state_in = ST_FQ;
         end
         ST_FQ: begin
            xs_in    = XS_S1;
            apos_in  = 1'b1;
            aneg_in  = 1'b1;
            state_in = ST_XGO;
         end
         ST_XGO: begin
            xstart   = 1'b1;
            state_in = ST_XWT;
         end
         ST_XWT: begin
            if (xres.done) begin
               case (xs_ff)
                  XS_CONVEX: begin
                     wr_en   = 1'b1;
                     wr_addr = ci_ff;
                     wr_data = {!xres.neg, by_ff, bx_ff};
                     state_in = ST_FA;
                     case (mode_ff)
                        MD_INIT: begin
                           if (CW'(ci_ff) + CW'(1) == n_ff) begin
                              mode_in = MD_SEARCH; ci_in = '0;
                           end else begin
                              ci_in = ci_ff + IW'(1);
                           end
                        end
                        MD_FIX1: begin
                           mode_in = MD_FIX2; ci_in = prev_ci;
                        end
                        default: begin
                           mode_in = MD_SEARCH; ci_in = '0;
                        end
                     endcase
                  end
                  XS_S1: begin
                     apos_in = apos_ff && pos3; aneg_in = aneg_ff && neg3;
                     xs_in = XS_S2; state_in = ST_XGO;
                  end
                  XS_S2: begin
                     apos_in = apos_ff && pos3; aneg_in = aneg_ff && neg3;
                     xs_in = XS_S3; state_in = ST_XGO;
                  end
                  default: begin
                     if ((apos_ff && pos3) || (aneg_ff && neg3)) begin
                        // a vertex lies strictly inside: not an ear
                        if (CW'(ci_ff) + CW'(1) == n_ff) begin
                           ci_in = '0; fb_in = 1'b1; mode_in = MD_EMIT;
                        end else begin
                           ci_in = ci_ff + IW'(1);
                        end
                        state_in = ST_FA;
                     end else if (k_ff == CW'(1)) begin
                        fb_in = 1'b0; mode_in = MD_EMIT; state_in = ST_FA;
                     end else begin
                        k_in = k_ff - CW'(1); pi_in = next_pi; state_in = ST_FP;
                     end
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               ear_in   = ci_ff;
               si_in    = ci_ff;
               if (CW'(ci_ff) + CW'(1) == n_ff) begin
                  n_in = n_dec;
                  if (n_dec >= CW'(3)) begin
                     ci_in = '0; mode_in = MD_FIX1; state_in = ST_FA;
                  end else begin
                     n_in = '0; ovf_in = 1'b0; state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_SHR;
               end
            end
         end
         ST_SHR: begin
            rd_addr  = si_ff + IW'(1);
            state_in = ST_SHW;
         end
         ST_SHW: begin
            wr_en   = 1'b1;
            wr_addr = si_ff;
            wr_data = rd_data_ff;
            si_in   = si_ff + IW'(1);
            if (CW'(si_ff) + CW'(2) < n_ff) begin
               state_in = ST_SHR;
            end else begin
               n_in = n_dec;
               if (n_dec >= CW'(3)) begin
                  ci_in = ear_ff; mode_in = MD_FIX1; state_in = ST_FA;
               end else begin
                  n_in = '0; ovf_in = 1'b0; state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MD_INIT;
         n_ff         <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         n_ff         <= n_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers without reset
   always_ff @(posedge clock) begin
      xs_ff   <= xs_in;
      k_ff    <= k_in;
      ci_ff   <= ci_in;
      pi_ff   <= pi_in;
      si_ff   <= si_in;
      ear_ff  <= ear_in;
      fb_ff   <= fb_in;
      apos_ff <= apos_in;
      aneg_ff <= aneg_in;
      if (state_ff == ST_FB) begin
         ax_ff <= rd_data_ff[CoordW-1:0];
         ay_ff <= rd_data_ff[2*CoordW-1:CoordW];
      end
      if (state_ff == ST_FC) begin
         bx_ff    <= rd_data_ff[CoordW-1:0];
         by_ff    <= rd_data_ff[2*CoordW-1:CoordW];
         bmark_ff <= rd_data_ff[MW-1];
      end
      if (state_ff == ST_FD) begin
         cx_ff <= rd_data_ff[CoordW-1:0];
         cy_ff <= rd_data_ff[2*CoordW-1:CoordW];
      end
      if (state_ff == ST_FQ) begin
         px_ff <= rd_data_ff[CoordW-1:0];
         py_ff <= rd_data_ff[2*CoordW-1:CoordW];
      end
   end

   // vertex store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // output register; next vertex is still in cx/cy when the triangle is queued
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {cy_ff, cx_ff, by_ff, bx_ff, ay_ff, ax_ff};
         rsp_last_ff <= (n_ff == CW'(3));
         rsp_user_ff <= {ovf_ff, fb_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ECT_ASSERT(a_count_cap, clock, reset, n_ff <= CW'(MAX_VERTS), "count beyond capacity")
   `ECT_ASSERT(a_work_count, clock, reset, (state_ff != ST_IDLE) |-> (n_ff >= CW'(3)), "short clip")
   `ECT_ASSERT(a_index_range, clock, reset, (state_ff != ST_IDLE) |-> (CW'(ci_ff) < n_ff), "index")
   `ECT_ASSERT_NEVER(a_stray_done, clock, reset, xres.done && (state_ff != ST_XWT), "stray done")

endmodule

### tb/tb_ear_clipping_triangulator.sv
// self-checking testbench of the ear clipping triangulator: directed and random polygons over the stream ports
// depends on ect_pkg and the rtl of ear_clipping_triangulator; no files or arguments are read
`timescale 1ns / 100ps

module tb_ear_clipping_triangulator;
   import ect_pkg::*;

   localparam int NumVerts  = EctMaxVerts;
   localparam int IdleLimit = 500000;   // cycles without any transaction before giving up
   localparam int HoldLen   = 3000;     // long receiver hold-off

   // one expected triangle
   typedef struct packed {
      logic [191:0] coords;   // prev_x, prev_y, ear_x, ear_y, next_x, next_y from the lowest bit
      logic         last_tri;
      logic         fallback;
      logic         dropped;
   } triangle_type;

   // polygon clipper mirror plus queue of triangles still owed by the block
   class triangle_scoreboard_type;
      logic [31:0]  xs[NumVerts];
      logic [31:0]  ys[NumVerts];
      bit           convex[NumVerts];
      int           count;
      bit           overflow;
      triangle_type owed_q[$];
      int           errors;

      function new();
         count = 0;
         overflow = 0;
         errors = 0;
      endfunction

      function longint px(int i);
         return longint'($signed(xs[i]));
      endfunction

      function longint py(int i);
         return longint'($signed(ys[i]));
      endfunction

      // sign of ux*vy - uy*vx, computed exactly at 68 bits
      function int cross_sign(longint ux, longint uy, longint vx, longint vy);
         logic signed [67:0] a, b, c, d, r;
         a = ux; b = vy; c = uy; d = vx;
         r = a * b - c * d;
         if (r < 0) return -1;
         if (r == 0) return 0;
         return 1;
      endfunction

      function int prev_of(int i, int n);
         return (i == 0) ? n - 1 : i - 1;
      endfunction

      function int next_of(int i, int n);
         return (i + 1 < n) ? i + 1 : 0;
      endfunction

      function bit convex_at(int i, int n);
         int a, b;
         a = prev_of(i, n);
         b = next_of(i, n);
         return cross_sign(px(a) - px(i), py(a) - py(i), px(b) - px(i), py(b) - py(i)) >= 0;
      endfunction

      // p strictly inside triangle a, b, c (either winding)
      function bit strictly_inside(int a, int b, int c, int p);
         int s1, s2, s3;
         s1 = cross_sign(px(b) - px(a), py(b) - py(a), px(p) - px(b), py(p) - py(b));
         s2 = cross_sign(px(c) - px(b), py(c) - py(b), px(p) - px(c), py(p) - py(c));
         s3 = cross_sign(px(a) - px(c), py(a) - py(c), px(p) - px(a), py(p) - py(a));
         return (s1 > 0 && s2 > 0 && s3 > 0) || (s1 < 0 && s2 < 0 && s3 < 0);
      endfunction

      function bit is_ear(int i, int n);
         int a, b;
         a = prev_of(i, n);
         b = next_of(i, n);
         for (int k = 0; k + 3 < n; k++)
            if (strictly_inside(a, i, b, (i + 2 + k) % n)) return 0;
         return 1;
      endfunction

      // accepted vertex transaction: store it, and clip the polygon when it closes
      function void note_vertex(logic [31:0] x, logic [31:0] y, logic last);
         int n, ear, a, b;
         bit fb;
         triangle_type t;
         if (count < NumVerts) begin
            xs[count] = x;
            ys[count] = y;
            count++;
         end else begin
            overflow = 1;
         end
         if (!last) return;
         n = count;
         if (n >= 3)
            for (int i = 0; i < n; i++) convex[i] = convex_at(i, n);
         while (n >= 3) begin
            fb = 1;
            ear = 0;
            for (int i = 0; i < n; i++) begin
               if (convex[i] && is_ear(i, n)) begin
                  ear = i;
                  fb = 0;
                  break;
               end
            end
            a = prev_of(ear, n);
            b = next_of(ear, n);
            t.coords   = {ys[b], xs[b], ys[ear], xs[ear], ys[a], xs[a]};
            t.last_tri = (n - 1 < 3);
            t.fallback = fb;
            t.dropped  = overflow;
            owed_q = {owed_q, t};
            for (int i = ear; i + 1 < n; i++) begin
               xs[i] = xs[i + 1];
               ys[i] = ys[i + 1];
               convex[i] = convex[i + 1];
            end
            n--;
            if (n >= 3) begin
               if (ear == n) ear = 0;
               convex[ear] = convex_at(ear, n);
               a = prev_of(ear, n);
               convex[a] = convex_at(a, n);
            end
         end
         count = 0;
         overflow = 0;
      endfunction

      task report(string what, logic [191:0] got, logic [191:0] exp);
         $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
         errors++;
      endtask

      // accepted triangle transaction against the oldest owed one
      task check_triangle(logic [191:0] data, logic last, logic [1:0] user);
         triangle_type t;
         if (owed_q.size() == 0) begin
            report("unexpected triangle", data, '0);
            return;
         end
         t = owed_q.pop_front();
         for (int f = 0; f < 6; f++)
            if (data[32*f +: 32] !== t.coords[32*f +: 32])
               report($sformatf("coordinate %0d", f), data[32*f +: 32], t.coords[32*f +: 32]);
         if (last !== t.last_tri) report("last_triangle", last, t.last_tri);
         if (user[0] !== t.fallback) report("fallback_used", user[0], t.fallback);
         if (user[1] !== t.dropped) report("vertices_dropped", user[1], t.dropped);
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  req_tdata;    // vertex_x, vertex_y
   logic         req_tlast;    // last_vertex
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [191:0] rsp_tdata;    // prev_x, prev_y, ear_x, ear_y, next_x, next_y
   logic         rsp_tlast;    // last_triangle
   logic [1:0]   rsp_tuser;    // fallback_used, vertices_dropped

   triangle_scoreboard_type sb;
   bit  hold_request;
   bit  random_stall;
   int  idle_cycles;

   ear_clipping_triangulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // mostly no gap, sometimes short, rarely long
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one vertex and wait for its transaction
   task send_vertex(logic [31:0] x, logic [31:0] y, logic last, bit gaps);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_vertex(x, y, last);
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
   endtask

   // random polygon; scale picks degenerate, moderate or full-range coordinates
   task send_polygon(int n, int scale);
      logic [31:0] x, y;
      for (int i = 0; i < n; i++) begin
         case (scale)
            0: begin
               x = $urandom_range(0, 6) - 3;
               y = $urandom_range(0, 6) - 3;
            end
            1: begin
               x = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
               y = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            end
            default: begin
               x = $urandom;
               y = $urandom;
            end
         endcase
         send_vertex(x, y, i == n - 1, 1);
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready && !reset) sb.check_triangle(rsp_tdata, rsp_tlast, rsp_tuser);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            hold_request = 0;
            for (int c = 0; c < HoldLen; c++) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (random_stall && $urandom_range(0, 3) == 0) begin
            stall = pick_gap();
            rsp_tready <= (stall == 0);
            if (stall > 0) begin
               repeat (stall) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      hold_request = 0;
      random_stall = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme corners, counter-clockwise then clockwise
      send_vertex(32'h8000_0000, 32'h8000_0000, 0, 0);
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 0, 0);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 1, 0);
      send_vertex(32'h8000_0000, 32'h8000_0000, 0, 0);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 0, 0);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1, 0);
      // concave arrow shape
      send_vertex(32'h0000_0000, 32'h0000_0000, 0, 0);
      send_vertex(32'h0004_0000, 32'h0000_0000, 0, 0);
      send_vertex(32'h0001_0000, 32'h0001_0000, 0, 0);
      send_vertex(32'h0004_0000, 32'h0004_0000, 0, 0);
      send_vertex(32'h0000_0000, 32'h0004_0000, 1, 0);
      // collinear and repeated points
      send_vertex(32'h0000_0001, 32'h0000_0001, 0, 0);
      send_vertex(32'h0000_0002, 32'h0000_0002, 0, 0);
      send_vertex(32'h0000_0003, 32'h0000_0003, 0, 0);
      send_vertex(32'h0000_0003, 32'h0000_0003, 1, 0);
      // short polygons give no triangle
      send_vertex(32'h1234_5678, 32'hfedc_ba98, 1, 0);
      send_vertex(32'hffff_ffff, 32'h0000_0000, 0, 0);
      send_vertex(32'h0000_0000, 32'hffff_ffff, 1, 0);
      // a clockwise square: every vertex is marked convex
      send_vertex(32'h0000_0000, 32'h0000_0000, 0, 0);
      send_vertex(32'h0000_0000, 32'h0002_0000, 0, 0);
      send_vertex(32'h0002_0000, 32'h0002_0000, 0, 0);
      send_vertex(32'h0002_0000, 32'h0000_0000, 1, 0);
      wait_drained();

      // overflow: a convex fan past capacity, extra vertices dropped
      random_stall = 1;
      for (int i = 0; i < NumVerts + 3; i++)
         send_vertex(i << 16, (i * i) << 8, i == NumVerts + 2, 1);
      // sender pauses until every owed triangle is back
      wait_drained();

      // receiver holds off while the sender keeps offering
      hold_request = 1;
      for (int p = 0; p < 4; p++) send_polygon($urandom_range(5, 9), 1);
      wait_drained();

      for (int p = 0; p < 50; p++) begin
         if ($urandom_range(0, 9) == 0) send_polygon($urandom_range(1, 2), 2);
         else send_polygon($urandom_range(3, 10), $urandom_range(0, 2));
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (500) @(posedge clock);
      if (sb.errors == 0 && sb.owed_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/ect_pkg.sv
rtl/ect_xunit.sv
rtl/ear_clipping_triangulator.sv
tb/tb_ear_clipping_triangulator.sv
